// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define AJB_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("jitter buffer assertion failed");

// Next-cycle implication, checked outside reset.
`define AJB_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("jitter buffer assertion failed");

`endif

// ----- design/ajb_pkg.sv -----
// Package: sizes, codes and word types of the audio jitter buffer.
`timescale 1ns / 1ps
package ajb_pkg;

  // ring and frame geometry
  localparam int CAPACITY_SAMPLES = 16384;
  localparam int FRAME_SAMPLES    = 64;
  localparam int PTR_W            = $clog2(CAPACITY_SAMPLES);
  localparam int FRAME_W          = $clog2(FRAME_SAMPLES + 1);

  // register widths and reset values
  localparam int HOLD_W  = 14;
  localparam int START_W = 8;
  localparam int CFG_W   = (HOLD_W > START_W) ? HOLD_W : START_W;
  localparam int CFG_IDX_W = 1;
  localparam logic [HOLD_W-1:0]  HOLD_RESET  = HOLD_W'(16000);
  localparam logic [START_W-1:0] START_RESET = START_W'(8);

  // compare widths
  localparam int CMP_W = (PTR_W > HOLD_W) ? PTR_W : HOLD_W;
  localparam int THR_W = START_W + FRAME_W;
  localparam int TC_W  = (PTR_W > THR_W) ? PTR_W : THR_W;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_HOLD = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_START    = 1'b1;

  // input action codes
  localparam logic [1:0] ACT_PUSH  = 2'd0;
  localparam logic [1:0] ACT_DRAIN = 2'd1;
  localparam logic [1:0] ACT_CLEAR = 2'd2;

  // result status codes
  localparam logic [1:0] ST_AUDIO = 2'd0;
  localparam logic [1:0] ST_WAIT  = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;

  // queue depths
  localparam int CQ_DEPTH  = 2;
  localparam int CQ_PTR_W  = (CQ_DEPTH > 1) ? $clog2(CQ_DEPTH) : 1;
  localparam int CQ_CNT_W  = $clog2(CQ_DEPTH + 1);
  localparam int RQ_DEPTH  = 4;
  localparam int RQ_PTR_W  = $clog2(RQ_DEPTH);
  localparam int RQ_CNT_W  = $clog2(RQ_DEPTH + 1);

  localparam logic [PTR_W-1:0] CAP_M1  = PTR_W'(CAPACITY_SAMPLES - 1);
  localparam logic [PTR_W:0]   CAP_EXT = (PTR_W + 1)'(CAPACITY_SAMPLES);

  typedef enum logic [1:0] {
    OP_PUSH,
    OP_DRAIN,
    OP_CLEAR
  } op_t;

  // command word from front to back
  typedef struct packed {
    op_t               op;
    logic signed [15:0] sample;
    logic              pend;
  } cmd_t;

  // result word held in the output queue
  typedef struct packed {
    logic [15:0] sample;
    logic [1:0]  status;
    logic        last;
    logic [31:0] under_total;
    logic [31:0] drop_total;
  } res_t;

  // ring position plus one, wrapping at capacity
  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    return (p == CAP_M1) ? '0 : p + 1'b1;
  endfunction

  // ring position plus an amount below capacity
  function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] p,
                                               input logic [PTR_W-1:0] amt);
    logic [PTR_W:0] s;
    s = {1'b0, p} + {1'b0, amt};
    if (s >= CAP_EXT) s = s - CAP_EXT;
    return s[PTR_W-1:0];
  endfunction

endpackage

// ----- design/ajb_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ajb_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- design/ajb_front.sv -----
// Front end: accepts input words, decodes the action and queues commands.
`timescale 1ns / 1ps
module ajb_front import ajb_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_push,
  output logic              in_full,
  input  logic [1:0]        in_action,
  input  logic signed [15:0] in_sample,
  input  logic              in_packet_end,
  output logic              cmd_valid,
  output cmd_t              cmd,
  input  logic              cmd_pop
);

  cmd_t                q_r [CQ_DEPTH];
  logic [CQ_PTR_W-1:0] wr_r, rd_r;
  logic [CQ_CNT_W-1:0] cnt_r;
  logic                acc, keep, take;
  cmd_t                dec;

  assign in_full   = (cnt_r == CQ_CNT_W'(CQ_DEPTH));
  assign cmd_valid = (cnt_r != '0);
  assign cmd       = q_r[rd_r];
  assign acc       = in_push && !in_full;
  assign take      = cmd_pop && cmd_valid;

  // classify the action; unknown codes are swallowed
  always_comb begin
    dec.sample = in_sample;
    dec.pend   = in_packet_end;
    dec.op     = OP_PUSH;
    keep       = 1'b1;
    case (in_action)
      ACT_PUSH:  dec.op = OP_PUSH;
      ACT_DRAIN: dec.op = OP_DRAIN;
      ACT_CLEAR: dec.op = OP_CLEAR;
      default:   keep = 1'b0;
    endcase
  end

  function automatic logic [CQ_PTR_W-1:0] qinc(input logic [CQ_PTR_W-1:0] p);
    return (p == CQ_PTR_W'(CQ_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // command queue
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (acc && keep) begin
        q_r[wr_r] <= dec;
        wr_r      <= qinc(wr_r);
      end
      if (take) rd_r <= qinc(rd_r);
      case ({acc && keep, take})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/ajb_res_q.sv -----
// Result queue: holds finished result words until the receiver pops them.
`timescale 1ns / 1ps
module ajb_res_q import ajb_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  res_t                din,
  input  logic                pop,
  output logic                empty,
  output logic [RQ_CNT_W-1:0] level,
  output res_t                head
);

  res_t                q_r [RQ_DEPTH];
  logic [RQ_PTR_W-1:0] wr_r, rd_r;
  logic [RQ_CNT_W-1:0] cnt_r;
  logic                take;

  assign empty = (cnt_r == '0);
  assign level = cnt_r;
  assign head  = q_r[rd_r];
  assign take  = pop && !empty;

  // circular storage; pointers wrap at the power-of-two depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        q_r[wr_r] <= din;
        wr_r      <= wr_r + 1'b1;
      end
      if (take) rd_r <= rd_r + 1'b1;
      case ({push, take})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

endmodule

// ----- design/ajb_back.sv -----
// Back end: ring storage, pointers, trimming, prebuffer and frame streaming.
`timescale 1ns / 1ps
module ajb_back import ajb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 cmd_valid,
  input  cmd_t                 cmd,
  output logic                 cmd_pop,
  input  logic [RQ_CNT_W-1:0]  rq_level,
  output logic                 rq_push,
  output res_t                 rq_din
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_TRIM,
    S_STREAM
  } state_t;

  state_t             state_r, state_nxt;
  logic [PTR_W-1:0]   wp_r, wp_nxt, rp_r, rp_nxt, fill_r, fill_nxt;
  logic               playing_r, playing_nxt;
  logic [31:0]        under_r, under_nxt, drop_r, drop_nxt;
  logic [HOLD_W-1:0]  hold_r;
  logic [START_W-1:0] start_r;
  logic [FRAME_W-1:0] cnt_r, cnt_nxt;
  logic               rd_vld_r, rd_vld_nxt, rd_last_r, rd_last_nxt;

  logic               ram_we, ram_re;
  logic [15:0]        ram_rdata;
  logic [RQ_CNT_W:0]  occ;
  logic               credit_ok, over_hold, go, is_last;
  logic [THR_W-1:0]   thr;
  logic [PTR_W-1:0]   amount;

  localparam logic [PTR_W-1:0] FRAME_P = PTR_W'(FRAME_SAMPLES);

  ajb_ram #(.WIDTH(16), .DEPTH(CAPACITY_SAMPLES)) u_ring (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wp_r),
    .wdata (cmd.sample),
    .re    (ram_re),
    .raddr (rp_r),
    .rdata (ram_rdata)
  );

  // room in the result queue, counting a read still in flight
  assign occ       = {1'b0, rq_level} + (RQ_CNT_W + 1)'(rd_vld_r);
  assign credit_ok = occ < (RQ_CNT_W + 1)'(RQ_DEPTH);

  assign over_hold = CMP_W'(fill_r) > CMP_W'(hold_r);
  assign thr       = THR_W'(start_r) * THR_W'(FRAME_SAMPLES);
  assign go        = playing_r || (TC_W'(fill_r) >= TC_W'(thr));
  assign amount    = (fill_r < FRAME_P) ? fill_r : FRAME_P;
  assign is_last   = (cnt_r == FRAME_W'(FRAME_SAMPLES - 1));

  // next-state logic
  always_comb begin
    state_nxt   = state_r;
    wp_nxt      = wp_r;
    rp_nxt      = rp_r;
    fill_nxt    = fill_r;
    playing_nxt = playing_r;
    under_nxt   = under_r;
    drop_nxt    = drop_r;
    cnt_nxt     = cnt_r;
    rd_vld_nxt  = 1'b0;
    rd_last_nxt = 1'b0;
    cmd_pop     = 1'b0;
    ram_we      = 1'b0;
    ram_re      = 1'b0;
    rq_push     = 1'b0;
    rq_din      = '0;

    // ring data read last cycle lands in the result queue
    if (rd_vld_r) begin
      rq_push            = 1'b1;
      rq_din.sample      = ram_rdata;
      rq_din.status      = ST_AUDIO;
      rq_din.last        = rd_last_r;
      rq_din.under_total = under_r;
      rq_din.drop_total  = drop_r;
    end

    case (state_r)
      S_IDLE: begin
        if (cmd_valid && !rd_vld_r) begin
          case (cmd.op)
            OP_PUSH: begin
              cmd_pop = 1'b1;
              ram_we  = 1'b1;
              wp_nxt  = ptr_inc(wp_r);
              // full at CAP_M1: oldest sample is dropped
              if (fill_r == CAP_M1) rp_nxt = ptr_inc(rp_r);
              else fill_nxt = fill_r + 1'b1;
              if (cmd.pend) state_nxt = S_TRIM;
            end
            OP_CLEAR: begin
              cmd_pop  = 1'b1;
              rp_nxt   = wp_r;
              fill_nxt = '0;
            end
            OP_DRAIN: begin
              if (credit_ok) begin
                cmd_pop            = 1'b1;
                rq_din.under_total = under_r;
                rq_din.drop_total  = drop_r;
                rq_din.last        = 1'b1;
                if (!go) begin
                  rq_push       = 1'b1;
                  rq_din.status = ST_WAIT;
                end else if (fill_r < FRAME_P) begin
                  rq_push            = 1'b1;
                  rq_din.status      = ST_UNDER;
                  playing_nxt        = 1'b0;
                  under_nxt          = under_r + 1'b1;
                  rq_din.under_total = under_r + 1'b1;
                end else begin
                  playing_nxt = 1'b1;
                  cnt_nxt     = '0;
                  state_nxt   = S_STREAM;
                end
              end
            end
            default: cmd_pop = 1'b1;
          endcase
        end
      end
      S_TRIM: begin
        // one frame per cycle; a short remainder empties the ring
        if (over_hold) begin
          rp_nxt   = ptr_add(rp_r, amount);
          fill_nxt = fill_r - amount;
          drop_nxt = drop_r + 1'b1;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_STREAM: begin
        if (credit_ok) begin
          ram_re      = 1'b1;
          rp_nxt      = ptr_inc(rp_r);
          fill_nxt    = fill_r - 1'b1;
          cnt_nxt     = cnt_r + 1'b1;
          rd_vld_nxt  = 1'b1;
          rd_last_nxt = is_last;
          if (is_last) state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state, pointers, counters and registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      wp_r      <= '0;
      rp_r      <= '0;
      fill_r    <= '0;
      playing_r <= 1'b0;
      under_r   <= '0;
      drop_r    <= '0;
      cnt_r     <= '0;
      rd_vld_r  <= 1'b0;
      rd_last_r <= 1'b0;
      hold_r    <= HOLD_RESET;
      start_r   <= START_RESET;
    end else begin
      state_r   <= state_nxt;
      wp_r      <= wp_nxt;
      rp_r      <= rp_nxt;
      fill_r    <= fill_nxt;
      playing_r <= playing_nxt;
      under_r   <= under_nxt;
      drop_r    <= drop_nxt;
      cnt_r     <= cnt_nxt;
      rd_vld_r  <= rd_vld_nxt;
      rd_last_r <= rd_last_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_MAX_HOLD: hold_r  <= cfg_data[HOLD_W-1:0];
          CFG_START:    start_r <= cfg_data[START_W-1:0];
          default:      hold_r  <= hold_r;
        endcase
      end
    end
  end

endmodule

// ----- design/audio_playback_jitter_buffer.sv -----
// Top level of the audio playback jitter buffer.
//
// Input channel: push/full queue of words {action, sample, packet_end};
// a word is taken when in_push is high and in_full is low. A two-entry
// command queue decouples the input from the ring engine.
// Result channel: empty/pop queue; the head word is valid while out_empty
// is low and leaves on out_pop. A four-entry result queue sits in front.
// A push writes its sample to the ring; with packet_end set it then starts
// a trim that drops frames of the oldest samples while the fill exceeds the
// max hold. A clear empties the ring. A drain that waits or underruns gives
// one result word; a playing drain streams FRAME_SAMPLES words off the
// single ring read port, one per cycle while the result queue has room.
// Reset clears pointers, counters, playback flag and queues; the ring
// contents are not cleared and need no sweep.
// A stalled receiver fills the result queue; the engine then pauses its ring
// reads and the command queue backs up to in_full.
// Configuration is written through cfg_we/cfg_index/cfg_data while idle;
// the user must keep to this, as the block itself does not enforce it.
`timescale 1ns / 1ps
module audio_playback_jitter_buffer import ajb_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_push,
  output logic                 in_full,
  input  logic [1:0]           in_action,
  input  logic signed [15:0]   in_sample,
  input  logic                 in_packet_end,
  output logic                 out_empty,
  input  logic                 out_pop,
  output logic signed [31:0]   out_audio_word,
  output logic [1:0]           out_status,
  output logic                 out_last,
  output logic [31:0]          out_underrun_total,
  output logic [31:0]          out_drop_total,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  logic                cmd_valid, cmd_pop, rq_push;
  cmd_t                cmd;
  res_t                rq_din, head;
  logic [RQ_CNT_W-1:0] rq_level;

  ajb_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_push       (in_push),
    .in_full       (in_full),
    .in_action     (in_action),
    .in_sample     (in_sample),
    .in_packet_end (in_packet_end),
    .cmd_valid     (cmd_valid),
    .cmd           (cmd),
    .cmd_pop       (cmd_pop)
  );

  ajb_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_pop   (cmd_pop),
    .rq_level  (rq_level),
    .rq_push   (rq_push),
    .rq_din    (rq_din)
  );

  ajb_res_q u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (rq_push),
    .din   (rq_din),
    .pop   (out_pop),
    .empty (out_empty),
    .level (rq_level),
    .head  (head)
  );

  // sample sits in the upper half of the audio word
  assign out_audio_word     = {head.sample, 16'h0000};
  assign out_status         = head.status;
  assign out_last           = head.last;
  assign out_underrun_total = head.under_total;
  assign out_drop_total     = head.drop_total;

endmodule

// ----- design/ajb_checker.sv -----
// Port-level checker for the audio jitter buffer, bound to the top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module ajb_checker import ajb_pkg::*; (
  input logic               clk,
  input logic               rst_n,
  input logic               out_empty,
  input logic               out_pop,
  input logic signed [31:0] out_audio_word,
  input logic [1:0]         out_status,
  input logic               out_last,
  input logic [31:0]        out_underrun_total,
  input logic [31:0]        out_drop_total
);

  // wait and underrun words end their drain and carry silence
  `AJB_ASSERT_IMP(a_flag_is_last, !out_empty && out_status != ST_AUDIO, out_last)
  `AJB_ASSERT_IMP(a_flag_silent, !out_empty && out_status != ST_AUDIO, out_audio_word == 32'sd0)
  // samples only occupy the upper half of the word
  `AJB_ASSERT_IMP(a_low_half_zero, !out_empty, out_audio_word[15:0] == 16'h0000)
  // a waiting head word holds until popped
  `AJB_ASSERT_NXT(a_head_holds, !out_empty && !out_pop,
                  !out_empty && $stable(out_audio_word) && $stable(out_status) &&
                  $stable(out_last) && $stable(out_underrun_total) &&
                  $stable(out_drop_total))

endmodule

bind audio_playback_jitter_buffer ajb_checker u_ajb_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .out_empty          (out_empty),
  .out_pop            (out_pop),
  .out_audio_word     (out_audio_word),
  .out_status         (out_status),
  .out_last           (out_last),
  .out_underrun_total (out_underrun_total),
  .out_drop_total     (out_drop_total)
);
